/* rtl/svfbd_pkg.sv */
package svfbd_pkg;

  // Field and register widths
  localparam int CoefW   = 25;
  localparam int VelW    = 17;
  localparam int StateW  = 32;
  localparam int SampleW = 16;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = StateW + CoefW + 1;

  // Q formats
  localparam int QFrac = 24;
  localparam int OutShift = 10;
  localparam logic [CoefW-1:0] Q24_ONE = 25'd16777216;
  localparam logic [VelW-1:0]  VEL_ONE = 17'd65536;

  // Register reset values
  localparam logic [CoefW-1:0] FREQ_RST  = 25'd294005;
  localparam logic [CoefW-1:0] DAMP_RST  = 25'd798915;
  localparam logic [CoefW-1:0] DECAY_RST = 25'd16776385;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_FREQ  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DAMP  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DECAY = 2'd2;

  // Request kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_TRIGGER = 1'b1;

  // Q24 product, wrapped to 32 bits (floor shift of the signed product)
  function automatic logic [StateW-1:0] q24_wrap(input logic signed [ProdW-1:0] p);
    q24_wrap = p[QFrac+StateW-1:QFrac];
  endfunction

endpackage

/* rtl/svfbd_mul.sv */
// Shared signed-by-unsigned multiplier with a registered product
module svfbd_mul (
  input  logic                              clk,
  input  logic signed [svfbd_pkg::StateW-1:0] mul_a,
  input  logic        [svfbd_pkg::CoefW-1:0]  mul_b,
  output logic signed [svfbd_pkg::ProdW-1:0]  prod_r
);
  import svfbd_pkg::*;

  logic signed [CoefW:0]   b_s;
  logic signed [ProdW-1:0] prod_nxt;

  assign b_s      = $signed({1'b0, mul_b});
  assign prod_nxt = ProdW'(mul_a) * ProdW'(b_s);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* rtl/svf_bass_drum_voice_unit.sv */
// Bass-drum voice: Chamberlin state-variable filter with a decaying envelope.
// Input channel (in_valid/in_ready): in_kind selects tick or trigger;
//   in_velocity (Q16, clamped to 1.0) is used by triggers only.
// A trigger loads a one-sample impulse and restarts the envelope and gives
//   no result.
// A tick runs one filter update and gives one sample on the output channel
//   (out_valid/out_ready): seven sequencer steps issue five multiplies in
//   turn to one shared 32x26 multiplier with a registered product, and the
//   last step presents the sample. in_ready is low until the sequencer is
//   back in idle, so no new request is taken until the tick is done.
// The sample sits in an output register; a new request can be taken while
//   it waits. If the receiver stalls and a second sample is finished, the
//   sequencer holds in its last step until the register frees.
// Configuration (cfg_we/cfg_index/cfg_data) writes take effect at once; the user
//   makes them only while the block is idle (not enforced); unknown indexes are ignored.
// Synchronous reset restores the coefficient defaults, clears filter state,
//   impulse and envelope, and empties the output register.
module svf_bass_drum_voice_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic        [svfbd_pkg::VelW-1:0]    in_velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [svfbd_pkg::SampleW-1:0] out_sample,
  input  logic                                cfg_we,
  input  logic        [svfbd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic        [svfbd_pkg::CoefW-1:0]   cfg_data
);
  import svfbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LP, S_QB, S_HP, S_BP, S_ENV, S_Y, S_DK
  } state_t;

  state_t state_r;

  logic [CoefW-1:0]  freq_r, damp_r, decay_r;
  logic [StateW-1:0] low_r, band_r, impulse_r, x_r, high_r;
  logic [CoefW-1:0]  env_r;
  logic signed [SampleW-1:0] hold_r;
  logic signed [SampleW-1:0] out_sample_r;
  logic              out_valid_r;

  logic                     accept;
  logic signed [StateW-1:0] mul_a;
  logic [CoefW-1:0]         mul_b;
  logic signed [ProdW-1:0]  prod_r;
  logic [StateW-1:0]        pq;
  logic [CoefW-1:0]         decay_sat;
  logic [VelW-1:0]          vel_c;
  logic [StateW-1:0]        impulse_nxt;
  logic signed [SampleW-1:0] sat_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign pq         = q24_wrap(prod_r);

  // Clamp decay and velocity to 1.0
  assign decay_sat = (decay_r > Q24_ONE) ? Q24_ONE : decay_r;
  assign vel_c     = (in_velocity > VEL_ONE) ? VEL_ONE : in_velocity;
  // velocity * 12 * 256
  assign impulse_nxt = (StateW'(vel_c) << 11) + (StateW'(vel_c) << 10);

  // Saturate (product >> 10) to 16 bits
  always_comb begin
    if (pq[StateW-1] && (pq[StateW-2:OutShift+SampleW-1] != '1)) begin
      sat_nxt = {1'b1, {(SampleW-1){1'b0}}};
    end else if (!pq[StateW-1] && (pq[StateW-2:OutShift+SampleW-1] != '0)) begin
      sat_nxt = {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      sat_nxt = $signed(pq[OutShift+SampleW-1:OutShift]);
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = $signed(band_r);
    mul_b = freq_r;
    unique case (state_r)
      S_IDLE: begin
        mul_a = $signed(band_r);
        mul_b = freq_r;
      end
      S_LP: begin
        mul_a = $signed(band_r);
        mul_b = damp_r;
      end
      S_QB, S_HP: begin
        mul_a = $signed(high_r);
        mul_b = freq_r;
      end
      S_BP, S_ENV: begin
        mul_a = $signed(band_r);
        mul_b = env_r;
      end
      S_Y, S_DK: begin
        mul_a = $signed(StateW'(env_r));
        mul_b = decay_sat;
      end
      default: begin
        mul_a = $signed(band_r);
        mul_b = freq_r;
      end
    endcase
  end

  svfbd_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= FREQ_RST;
      damp_r  <= DAMP_RST;
      decay_r <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FREQ:  freq_r  <= cfg_data;
        REG_DAMP:  damp_r  <= cfg_data;
        REG_DECAY: decay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, voice state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= '0;
      band_r      <= '0;
      impulse_r   <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // last step refills the output register itself
      if (out_valid_r && out_ready && (state_r != S_DK)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_kind == KIND_TRIGGER) begin
              impulse_r <= impulse_nxt;
              env_r     <= Q24_ONE;
            end else begin
              x_r       <= impulse_r;
              impulse_r <= '0;
              state_r   <= S_LP;
            end
          end
        end
        // low += f*band
        S_LP: begin
          low_r   <= low_r + pq;
          state_r <= S_QB;
        end
        // high = x - low - q*band
        S_QB: begin
          high_r  <= x_r - low_r - pq;
          state_r <= S_HP;
        end
        S_HP: state_r <= S_BP;
        // band += f*high
        S_BP: begin
          band_r  <= band_r + pq;
          state_r <= S_ENV;
        end
        S_ENV: state_r <= S_Y;
        // y = band*env, shifted and saturated
        S_Y: begin
          hold_r  <= sat_nxt;
          state_r <= S_DK;
        end
        // env *= decay, present sample
        S_DK: begin
          if (!out_valid_r || out_ready) begin
            env_r        <= prod_r[QFrac+CoefW-1:QFrac];
            out_sample_r <= hold_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
